// ===== rtl/sdinit_pkg.sv =====
// Package for the SD card init sequencer core: phase, status and command codes.
// No dependencies; imported by sd_card_init_sequencer_core.
package sdinit_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_W0    = 4'd1,
      PH_W8    = 4'd2,
      PH_W55   = 4'd3,
      PH_W41   = 4'd4,
      PH_W2    = 4'd5,
      PH_W3    = 4'd6,
      PH_W9    = 4'd7,
      PH_W7    = 4'd8,
      PH_READY = 4'd9,
      PH_ERR   = 4'd10,
      PH_TMO   = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_BUSY     = 3'd0,
      SEQ_READY    = 3'd1,
      SEQ_ERROR    = 3'd2,
      SEQ_TIMEOUT  = 3'd3,
      SEQ_TRANSFER = 3'd4
   } seq_status_type;

   typedef enum logic [1:0] {
      REQ_START    = 2'd0,
      REQ_COMPLETE = 2'd1,
      REQ_TRANSFER = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   localparam logic [1:0] CMD_STATUS_OK  = 2'd0;
   localparam logic [1:0] CMD_STATUS_ERR = 2'd1;
   localparam logic [1:0] CMD_STATUS_TMO = 2'd2;
   localparam logic [1:0] CMD_STATUS_BAD = 2'd3;

   localparam logic [1:0] RESP_NONE  = 2'd0;
   localparam logic [1:0] RESP_R136  = 2'd1;
   localparam logic [1:0] RESP_R48   = 2'd2;
   localparam logic [1:0] RESP_R48B  = 2'd3;

   localparam logic [5:0] CMD_CARD_RESET  = 6'd0;
   localparam logic [5:0] CMD_GET_CID     = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
   localparam logic [5:0] CMD_SELECT      = 6'd7;
   localparam logic [5:0] CMD_SEND_IF     = 6'd8;
   localparam logic [5:0] CMD_GET_CSD     = 6'd9;
   localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
   localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
   localparam logic [5:0] CMD_SD_SEND_OP  = 6'd41;
   localparam logic [5:0] CMD_APP_PREFIX  = 6'd55;

   localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
   localparam logic [11:0] IF_ECHO      = 12'h1AA;
   localparam logic [31:0] OCR_ARG_HCS  = 32'h40FF_8000;
   localparam logic [31:0] OCR_ARG_SDSC = 32'h00FF_8000;
   localparam logic [7:0]  RETRIES_RST  = 8'd100;

   localparam int IN_DATA_W  = 200;
   localparam int OUT_DATA_W = 96;

   typedef struct packed {
      logic           cmd_valid;
      logic [5:0]     cmd_index;
      logic [31:0]    cmd_arg;
      logic [1:0]     resp_kind;
      logic           has_data;
      logic           read_dir;
      seq_status_type seq_status;
      logic           high_capacity;
      logic [15:0]    card_address;
      logic [31:0]    total_sectors;
      logic           run_end;
   } rsp_type;

endpackage

// ===== rtl/sd_card_init_sequencer_core.sv =====
// SD card init sequencer core: bring-up command sequence and single-block transfer issue.
// Depends on sdinit_pkg.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata, req_tuser (request kind), req_tlast
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tlast (run end)
//  csr     | in  | csr_valid/csr_ready   | csr_data (op_cond_retries)
//
// One word in, one word out. A word is registered in the input register, the
// sequencer step runs between it and the output register; one word per cycle
// sustained while rsp_tready holds. Each stage holds while the stage after it is
// full and stalled. Synchronous reset clears phase, card info and both valids;
// csr_ready is always high.
module sd_card_init_sequencer_core
   import sdinit_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] cmd_status, [33:2] resp_word0, [65:34] resp_word1, [97:66] resp_word2,
   // [129:98] resp_word3, [161:130] start_sector, [193:162] block_offset,
   // [194] write_dir, [199:195] zero
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] cmd_valid, [6:1] cmd_index, [38:7] cmd_arg, [40:39] resp_kind, [41] has_data,
   // [42] read_dir, [45:43] seq_status, [46] high_capacity, [62:47] card_address,
   // [94:63] total_sectors, [95] zero
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);

   logic                 in_valid_ff;
   logic [IN_DATA_W-1:0] in_data_ff;
   logic [1:0]           in_type_ff;
   logic                 in_last_ff;

   phase_type   phase_ff, phase_in;
   logic        is_v2_ff, is_v2_in;
   logic        hc_ff, hc_in;
   logic [15:0] rca_ff, rca_in;
   logic [31:0] sectors_ff, sectors_in;
   logic [7:0]  retries_ff, retries_in;
   logic [7:0]  op_retries_ff;

   logic    out_valid_ff;
   rsp_type out_ff, out_in;

   logic out_free;
   logic advance;

   logic [1:0]  f_status;
   logic [31:0] f_w0, f_w1, f_w2, f_w3, f_sector, f_offset;
   logic        f_wr;
   logic        ok;
   logic [31:0] blk_addr;
   logic [22:0] csize_p1;

   assign f_status = in_data_ff[1:0];
   assign f_w0     = in_data_ff[33:2];
   assign f_w1     = in_data_ff[65:34];
   assign f_w2     = in_data_ff[97:66];
   assign f_w3     = in_data_ff[129:98];
   assign f_sector = in_data_ff[161:130];
   assign f_offset = in_data_ff[193:162];
   assign f_wr     = in_data_ff[194];

   assign ok       = (f_status == CMD_STATUS_OK);
   assign blk_addr = f_sector + f_offset;
   assign csize_p1 = {1'b0, f_w2[5:0], f_w1[31:16]} + 23'd1;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_type_ff <= req_tuser;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_retries_ff <= RETRIES_RST;
      end else if (csr_valid) begin
         op_retries_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         is_v2_ff   <= 1'b0;
         hc_ff      <= 1'b0;
         rca_ff     <= '0;
         sectors_ff <= '0;
         retries_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         is_v2_ff   <= is_v2_in;
         hc_ff      <= hc_in;
         rca_ff     <= rca_in;
         sectors_ff <= sectors_in;
         retries_ff <= retries_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      is_v2_in   = is_v2_ff;
      hc_in      = hc_ff;
      rca_in     = rca_ff;
      sectors_in = sectors_ff;
      retries_in = retries_ff;
      out_in     = '0;

      unique case (req_kind_type'(in_type_ff))
         REQ_START: begin
            is_v2_in         = 1'b0;
            out_in.cmd_valid = 1'b1;
            out_in.cmd_index = CMD_CARD_RESET;
            out_in.resp_kind = RESP_NONE;
            phase_in         = PH_W0;
         end
         REQ_COMPLETE: begin
            unique case (phase_ff)
               PH_W0: begin
                  out_in.cmd_valid = 1'b1;
                  out_in.cmd_index = CMD_SEND_IF;
                  out_in.cmd_arg   = IF_COND_ARG;
                  out_in.resp_kind = RESP_R48;
                  phase_in         = PH_W8;
               end
               PH_W8: begin
                  if (ok && f_w0[11:0] == IF_ECHO) begin
                     is_v2_in = 1'b1;
                  end
                  retries_in       = op_retries_ff;
                  out_in.cmd_valid = 1'b1;
                  out_in.cmd_index = CMD_APP_PREFIX;
                  out_in.cmd_arg   = {rca_ff, 16'h0000};
                  out_in.resp_kind = RESP_R48;
                  phase_in         = PH_W55;
               end
               PH_W55, PH_W41: begin
                  if (ok && phase_ff == PH_W55) begin
                     out_in.cmd_valid = 1'b1;
                     out_in.cmd_index = CMD_SD_SEND_OP;
                     out_in.cmd_arg   = is_v2_ff ? OCR_ARG_HCS : OCR_ARG_SDSC;
                     out_in.resp_kind = RESP_R48;
                     phase_in         = PH_W41;
                  end else if (ok && phase_ff == PH_W41 && f_w0[31]) begin
                     hc_in            = f_w0[30];
                     out_in.cmd_valid = 1'b1;
                     out_in.cmd_index = CMD_GET_CID;
                     out_in.resp_kind = RESP_R136;
                     phase_in         = PH_W2;
                  end else if (retries_ff == 8'd0) begin
                     phase_in = PH_TMO;
                  end else begin
                     retries_in       = retries_ff - 8'd1;
                     out_in.cmd_valid = 1'b1;
                     out_in.cmd_index = CMD_APP_PREFIX;
                     out_in.cmd_arg   = {rca_ff, 16'h0000};
                     out_in.resp_kind = RESP_R48;
                     phase_in         = PH_W55;
                  end
               end
               PH_W2: begin
                  if (ok) begin
                     out_in.cmd_valid = 1'b1;
                     out_in.cmd_index = CMD_SEND_RCA;
                     out_in.resp_kind = RESP_R48;
                     phase_in         = PH_W3;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_W3: begin
                  if (ok) begin
                     rca_in           = f_w0[31:16];
                     out_in.cmd_valid = 1'b1;
                     out_in.cmd_index = CMD_GET_CSD;
                     out_in.cmd_arg   = {f_w0[31:16], 16'h0000};
                     out_in.resp_kind = RESP_R136;
                     phase_in         = PH_W9;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_W9: begin
                  // CSD v2 only: (C_SIZE + 1) * 1024, wraps at 32 bits
                  if (ok && f_w3[31:30] == 2'b01) begin
                     sectors_in = {csize_p1[21:0], 10'd0};
                  end
                  out_in.cmd_valid = 1'b1;
                  out_in.cmd_index = CMD_SELECT;
                  out_in.cmd_arg   = {rca_ff, 16'h0000};
                  out_in.resp_kind = RESP_R48B;
                  phase_in         = PH_W7;
               end
               PH_W7: begin
                  phase_in = ok ? PH_READY : PH_ERR;
               end
               default: begin
               end
            endcase
         end
         REQ_TRANSFER: begin
            if (phase_ff == PH_READY) begin
               out_in.cmd_valid = 1'b1;
               out_in.cmd_index = f_wr ? CMD_WRITE_BLOCK : CMD_READ_BLOCK;
               out_in.cmd_arg   = hc_ff ? blk_addr : {blk_addr[22:0], 9'd0};
               out_in.resp_kind = RESP_R48;
               out_in.has_data  = 1'b1;
               out_in.read_dir  = !f_wr;
               out_in.run_end   = in_last_ff;
            end
         end
         default: begin
         end
      endcase

      if (out_in.has_data) begin
         out_in.seq_status = SEQ_TRANSFER;
      end else if (phase_in == PH_READY) begin
         out_in.seq_status = SEQ_READY;
      end else if (phase_in == PH_ERR) begin
         out_in.seq_status = SEQ_ERROR;
      end else if (phase_in == PH_TMO) begin
         out_in.seq_status = SEQ_TIMEOUT;
      end else begin
         out_in.seq_status = SEQ_BUSY;
      end
      out_in.high_capacity = hc_in;
      out_in.card_address  = rca_in;
      out_in.total_sectors = sectors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.run_end;
   assign rsp_tdata  = {1'b0, out_ff.total_sectors, out_ff.card_address,
                        out_ff.high_capacity, out_ff.seq_status, out_ff.read_dir,
                        out_ff.has_data, out_ff.resp_kind, out_ff.cmd_arg,
                        out_ff.cmd_index, out_ff.cmd_valid};

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.cmd_valid |->
         out_ff.cmd_index == '0 && out_ff.cmd_arg == '0 && out_ff.resp_kind == RESP_NONE)
      else $error("command fields set without a command");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ff.has_data == (out_ff.seq_status == SEQ_TRANSFER))
      else $error("transfer status and data flag disagree");

   a_run_end_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.run_end |-> out_ff.has_data)
      else $error("run end without a transfer");

   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> phase_ff == $past(phase_ff))
      else $error("phase moved without a word");

   a_transfer_ready: assert property (@(posedge clock) disable iff (reset)
      advance && out_in.has_data |-> phase_ff == PH_READY)
      else $error("transfer issued before ready");

endmodule
